// ----- rtl/core/tbse_pkg.sv -----
// Shared types and codes for the two-level bitmap set engine.
// Holds the transaction structs, command codes and word-unit control types.
// No dependencies.
package tbse_pkg;

    // Node identifier and count widths
    localparam int ID_W      = 10;
    localparam int COUNT_W   = 11;
    localparam int ONES_W    = 7;   // popcount of one word of up to 64 bits
    localparam int BITPOS_W  = 6;   // bit position inside one word of up to 64 bits
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Command codes
    localparam logic [2:0] CMD_SET_BIT   = 3'd0;
    localparam logic [2:0] CMD_CLR_BIT   = 3'd1;
    localparam logic [2:0] CMD_SET_RANGE = 3'd2;
    localparam logic [2:0] CMD_CLR_RANGE = 3'd3;
    localparam logic [2:0] CMD_TEST      = 3'd4;
    localparam logic [2:0] CMD_FIRST     = 3'd5;
    localparam logic [2:0] CMD_NEXT      = 3'd6;
    localparam logic [2:0] CMD_CLR_ALL   = 3'd7;

    // Word unit operations
    localparam logic [1:0] WOP_SET  = 2'd0;
    localparam logic [1:0] WOP_CLR  = 2'd1;
    localparam logic [1:0] WOP_SCAN = 2'd2;
    localparam logic [1:0] WOP_WIPE = 2'd3;

    // Register select (address bit 2)
    localparam logic REG_HIGHEST_ID = 1'b0;
    localparam logic REG_SUMMARY_EN = 1'b1;

    typedef struct packed {
        logic [2:0]      command;
        logic [ID_W-1:0] node_low;
        logic [ID_W-1:0] node_high;
    } tbse_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] changed_count;
        logic               is_member;
        logic [ID_W-1:0]    found_node;
        logic               found_valid;
        logic               id_error;
    } tbse_res_t;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] rlo;
        logic [ID_W-1:0] rhi;
    } wu_ctl_t;

    typedef struct packed {
        logic                hit;
        logic [ONES_W-1:0]   ones;
        logic [BITPOS_W-1:0] first_bit;
    } wu_res_t;

endpackage

// ----- rtl/core/tbse_word_unit.sv -----
// Shared per-word unit: builds the range mask for one bitmap word, applies
// set or clear, counts changed bits and finds the lowest hit.
// Depends on tbse_pkg.
module tbse_word_unit #(
    parameter int WORD_BITS = 64
) (
    input  tbse_pkg::wu_ctl_t                ctl,
    input  logic [tbse_pkg::ID_W-1:0]        base,
    input  logic [WORD_BITS-1:0]             word,
    output logic [WORD_BITS-1:0]             new_word,
    output tbse_pkg::wu_res_t                res
);
    import tbse_pkg::*;

    localparam logic [WORD_BITS-1:0] ONES = '1;
    localparam logic [ID_W-1:0]      LAST = ID_W'(WORD_BITS - 1);

    logic [ID_W-1:0]      dlo;
    logic [ID_W-1:0]      dhi;
    logic [WORD_BITS-1:0] mlo;
    logic [WORD_BITS-1:0] mhi;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] chg;
    logic [WORD_BITS-1:0] hits;

    // Build the low and high edges of the range mask relative to this word
    always_comb begin
        dlo = ctl.rlo - base;
        dhi = ctl.rhi - base;
        if (ctl.rlo <= base) begin
            mlo = ONES;
        end else if (dlo <= LAST) begin
            mlo = ONES << dlo;
        end else begin
            mlo = '0;
        end
        if (ctl.rhi < base) begin
            mhi = '0;
        end else if (dhi >= LAST) begin
            mhi = ONES;
        end else begin
            mhi = ONES >> (LAST - dhi);
        end
        mask = (ctl.op == WOP_WIPE) ? ONES : (mlo & mhi);
    end

    // Apply the operation and keep only the bits that really change
    always_comb begin
        unique case (ctl.op)
            WOP_SET: begin
                chg      = mask & ~word;
                new_word = word | chg;
            end
            WOP_CLR, WOP_WIPE: begin
                chg      = mask & word;
                new_word = word & ~chg;
            end
            default: begin
                chg      = '0;
                new_word = word;
            end
        endcase
    end

    // Count changes and locate the lowest set bit inside the mask
    always_comb begin
        hits          = word & mask;
        res.hit       = |hits;
        res.ones      = ONES_W'($countones(chg));
        res.first_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hits[j]) begin
                res.first_bit = BITPOS_W'(j);
            end
        end
    end

endmodule

// ----- rtl/core/two_level_bitmap_set_engine_core.sv -----
// Top level of the two-level bitmap set engine: command sequencer, word
// memory, summary flags, configuration registers and result register.
// Depends on tbse_pkg and tbse_word_unit.
//
// Usage:
//   Commands arrive on s_valid/s_ready/s_data, one transaction per command;
//   each command gives exactly one result on m_valid/m_ready/m_data.
//   Configuration (highest node id at 0x0, summary enable at 0x4) is to be
//   written over APB while idle (the block does not check); pready is always high.
// Timing:
//   Bit, range, test, search and clear-all commands sweep the word memory
//   through one shared word unit, one word per cycle with a registered
//   memory read; the next command is taken once the result is in the output
//   register. Searches stop at the first hit, and with the summary enabled
//   they stop as soon as no later word is marked non-empty. Rejected
//   commands, inverted ranges and next-after-highest skip the sweep.
//   One command is in work at a time; s_ready is low while it runs.
// Reset and stall:
//   Reset empties the set by clearing the summary flags (the words need no
//   clearing pass) and restores the registers. A finished result waits in
//   the output register while the next command is accepted; if that result
//   is still not taken when the next finishes, the engine holds until it is.
module two_level_bitmap_set_engine_core #(
    parameter int MAX_NODES = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tbse_pkg::tbse_cmd_t            s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tbse_pkg::tbse_res_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbse_pkg::PADDR_W-1:0]   paddr,
    input  logic [tbse_pkg::PDATA_W-1:0]   pwdata,
    output logic [tbse_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import tbse_pkg::*;

    // Identifiers are ID_W bits wide, so storage beyond that range is never used
    localparam int NODES_EFF = (MAX_NODES < (1 << ID_W)) ? MAX_NODES : (1 << ID_W);
    localparam int NWORDS    = (NODES_EFF + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int RCNT_W    = $clog2(NWORDS + 1);

    localparam logic [ID_W-1:0]   LIMIT_CAP = ID_W'(NODES_EFF - 1);
    localparam logic [ID_W-1:0]   BASE_STEP = ID_W'(WORD_BITS);
    localparam logic [WIDX_W-1:0] LAST_IDX  = WIDX_W'(NWORDS - 1);
    localparam logic [RCNT_W-1:0] RD_END    = RCNT_W'(NWORDS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // Word storage and summary flags
    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [NWORDS-1:0]    summary_reg, summary_next;

    // Control and configuration registers
    logic [1:0]          state_reg, state_next;
    logic [ID_W-1:0]     hid_reg;
    logic                sen_reg;
    logic [2:0]          cmd_reg, cmd_next;
    wu_ctl_t             ctl_reg, ctl_next;
    logic [RCNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                proc_vld_reg, proc_vld_next;
    logic [WIDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic [ID_W-1:0]     base_reg, base_next;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                rd_summ_reg;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                member_reg, member_next;
    logic [ID_W-1:0]     found_reg, found_next;
    logic                fvalid_reg, fvalid_next;
    logic                err_reg, err_next;
    logic                m_valid_reg, m_valid_next;
    tbse_res_t           m_data_reg, m_data_next;

    // Datapath signals
    logic [ID_W-1:0]      top_id;
    logic                 s_fire;
    logic                 rd_en;
    logic                 wr_en;
    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS-1:0] word_out;
    wu_res_t              wu_res;
    logic                 hit_stop;
    logic                 last_word;
    logic                 rest_empty;
    logic                 early_stop;
    logic                 dec_err;
    logic                 dec_skip;
    wu_ctl_t              dec_ctl;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign top_id  = (hid_reg > LIMIT_CAP) ? LIMIT_CAP : hid_reg;

    // Shared word unit
    tbse_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .ctl      (ctl_reg),
        .base     (base_reg),
        .word     (word_in),
        .new_word (word_out),
        .res      (wu_res)
    );

    // A word whose summary flag is clear reads as empty
    assign word_in    = rd_summ_reg ? rd_word_reg : '0;
    assign rd_en      = (state_reg == ST_RUN) && (rd_idx_reg < RD_END);
    assign wr_en      = proc_vld_reg && (ctl_reg.op != WOP_SCAN);
    assign hit_stop   = proc_vld_reg && (ctl_reg.op == WOP_SCAN) && wu_res.hit;
    assign last_word  = proc_vld_reg && (proc_idx_reg == LAST_IDX);
    assign rest_empty = ((summary_reg >> rd_idx_reg) == '0);
    assign early_stop = (state_reg == ST_RUN) && (ctl_reg.op == WOP_SCAN) && sen_reg
                        && rest_empty;

    // Decode an incoming command into error, skip and word-unit control
    always_comb begin
        dec_err     = 1'b0;
        dec_skip    = 1'b0;
        dec_ctl.op  = WOP_SCAN;
        dec_ctl.rlo = s_data.node_low;
        dec_ctl.rhi = s_data.node_low;
        unique case (s_data.command)
            CMD_SET_BIT, CMD_CLR_BIT: begin
                dec_err    = (s_data.node_low > top_id);
                dec_ctl.op = (s_data.command == CMD_SET_BIT) ? WOP_SET : WOP_CLR;
            end
            CMD_SET_RANGE, CMD_CLR_RANGE: begin
                dec_err     = (s_data.node_low > top_id) || (s_data.node_high > top_id);
                dec_skip    = (s_data.node_low > s_data.node_high);
                dec_ctl.op  = (s_data.command == CMD_SET_RANGE) ? WOP_SET : WOP_CLR;
                dec_ctl.rhi = s_data.node_high;
            end
            CMD_TEST: begin
                dec_err = (s_data.node_low > top_id);
            end
            CMD_FIRST: begin
                dec_ctl.rlo = '0;
                dec_ctl.rhi = top_id;
            end
            CMD_NEXT: begin
                dec_err     = (s_data.node_low > top_id);
                dec_skip    = (s_data.node_low == top_id);
                dec_ctl.rlo = s_data.node_low + ID_W'(1);
                dec_ctl.rhi = top_id;
            end
            CMD_CLR_ALL: begin
                dec_ctl.op  = WOP_WIPE;
                dec_ctl.rlo = '0;
                dec_ctl.rhi = '1;
            end
            default: begin
                dec_ctl.op = WOP_SCAN;
            end
        endcase
    end

    // Sequencer: accept, sweep words, collect the result, hand it off
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        ctl_next      = ctl_reg;
        rd_idx_next   = rd_idx_reg;
        proc_vld_next = proc_vld_reg;
        proc_idx_next = proc_idx_reg;
        base_next     = base_reg;
        summary_next  = summary_reg;
        cnt_next      = cnt_reg;
        member_next   = member_reg;
        found_next    = found_reg;
        fvalid_next   = fvalid_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        // Drop the output once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next      = s_data.command;
                    ctl_next      = dec_ctl;
                    rd_idx_next   = '0;
                    proc_vld_next = 1'b0;
                    base_next     = '0;
                    cnt_next      = '0;
                    member_next   = 1'b0;
                    found_next    = '0;
                    fvalid_next   = 1'b0;
                    err_next      = dec_err;
                    state_next    = (dec_err || dec_skip) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (wr_en) begin
                    summary_next[proc_idx_reg] = (word_out != '0);
                    cnt_next = cnt_reg + COUNT_W'(wu_res.ones);
                end
                if (hit_stop) begin
                    if (cmd_reg == CMD_TEST) begin
                        member_next = 1'b1;
                    end else begin
                        found_next  = base_reg + ID_W'(wu_res.first_bit);
                        fvalid_next = 1'b1;
                    end
                end
                if (hit_stop || last_word || early_stop) begin
                    proc_vld_next = 1'b0;
                    state_next    = ST_DONE;
                end else begin
                    proc_vld_next = rd_en;
                    proc_idx_next = rd_idx_reg[WIDX_W-1:0];
                    if (rd_en) begin
                        rd_idx_next = rd_idx_reg + RCNT_W'(1);
                    end
                    if (proc_vld_reg) begin
                        base_next = base_reg + BASE_STEP;
                    end
                end
            end
            ST_DONE, ST_HOLD: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.changed_count = cnt_reg;
                    m_data_next.is_member     = member_reg;
                    m_data_next.found_node    = found_reg;
                    m_data_next.found_valid   = fvalid_reg;
                    m_data_next.id_error      = err_reg;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Word memory: one read and one write port, read data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg <= mem[rd_idx_reg[WIDX_W-1:0]];
            rd_summ_reg <= summary_reg[rd_idx_reg[WIDX_W-1:0]];
        end
        if (wr_en && (state_reg == ST_RUN)) begin
            mem[proc_idx_reg] <= word_out;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            proc_vld_reg <= 1'b0;
            summary_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            proc_vld_reg <= proc_vld_next;
            summary_reg  <= summary_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ctl_reg      <= ctl_next;
        rd_idx_reg   <= rd_idx_next;
        proc_idx_reg <= proc_idx_next;
        base_reg     <= base_next;
        cnt_reg      <= cnt_next;
        member_reg   <= member_next;
        found_reg    <= found_next;
        fvalid_reg   <= fvalid_next;
        err_reg      <= err_next;
        m_data_reg   <= m_data_next;
    end

    // Configuration registers, selected by address bit 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hid_reg <= '1;
            sen_reg <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HIGHEST_ID) begin
                hid_reg <= pwdata[ID_W-1:0];
            end else begin
                sen_reg <= pwdata[0];
            end
        end
    end

    // Register readback
    always_comb begin
        if (paddr[2] == REG_HIGHEST_ID) begin
            prdata = {{(PDATA_W - ID_W){1'b0}}, hid_reg};
        end else begin
            prdata = {{(PDATA_W - 1){1'b0}}, sen_reg};
        end
    end

`ifndef ASSERT_OFF
    // No word is in flight while the engine takes commands
    a_idle_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !proc_vld_reg)
        else $error("word in flight while idle");

    // An accepted command closes the input until its result is built
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("second command accepted while busy");

    // A rejected command reports nothing else
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.id_error) |-> ((m_data.changed_count == '0) &&
            !m_data.found_valid && !m_data.is_member))
        else $error("rejected command reports a result");

    // A written word leaves its summary flag matching its contents
    a_summary_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && (state_reg == ST_RUN)) |=>
            (summary_reg[$past(proc_idx_reg)] == ($past(word_out) != '0)))
        else $error("summary flag out of step with word");
`endif

endmodule
